// ----- design/multitouch_slot_tracker_assert.svh -----
// Assertion macros used by the slot tracker datapath (mst_dp).
`ifndef MULTITOUCH_SLOT_TRACKER_ASSERT_SVH
`define MULTITOUCH_SLOT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mst_pkg.sv -----
// Package: event codes, limits and controller/datapath handshake types.
`timescale 1ns / 1ps
package mst_pkg;

  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_POLL  = 1'b1;

  localparam logic [15:0] TYPE_ABS   = 16'h0003;
  localparam logic [15:0] CODE_SLOT  = 16'h002f;
  localparam logic [15:0] CODE_TRACK = 16'h0039;
  localparam logic [15:0] CODE_X     = 16'h0035;
  localparam logic [15:0] CODE_Y     = 16'h0036;

  // A poll report never exceeds this many points.
  localparam int RESULT_LIMIT = 8;
  localparam int CNT_W        = $clog2(RESULT_LIMIT);

  typedef struct packed {
    logic apply_ev;
    logic start_scan;
    logic advance;
    logic emit;
    logic emit_empty;
  } mst_cmd_t;

  typedef struct packed {
    logic any_active;
    logic cur_active;
    logic cur_last;
    logic out_free;
  } mst_sts_t;

endpackage

// ----- design/mst_if.sv -----
// Channel interfaces: event/poll input and contact report output.
`timescale 1ns / 1ps
interface mst_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic        [15:0] ev_type;
  logic        [15:0] ev_code;
  logic signed [31:0] ev_value;

  modport source (output valid, req_type, ev_type, ev_code, ev_value, input ready);
  modport sink   (input valid, req_type, ev_type, ev_code, ev_value, output ready);
endinterface

interface mst_out_if;
  logic               valid;
  logic               ready;
  logic               point_valid;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic        [2:0]  finger_index;
  logic               last;

  modport source (output valid, point_valid, pos_x, pos_y, finger_index, last,
                  input ready);
  modport sink   (input valid, point_valid, pos_x, pos_y, finger_index, last,
                  output ready);
endinterface

// ----- design/mst_ctrl.sv -----
// Controller: accepts transactions and sequences the poll scan.
`timescale 1ns / 1ps
module mst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  input  mst_pkg::mst_sts_t sts,
  output mst_pkg::mst_cmd_t cmd
);

  typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == mst_pkg::REQ_POLL) begin
            cmd.start_scan = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.apply_ev = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!sts.any_active) begin
          if (sts.out_free) begin
            cmd.emit_empty = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (sts.cur_active) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            if (sts.cur_last) begin
              state_nxt = ST_IDLE;
            end else begin
              cmd.advance = 1'b1;
            end
          end
        end else begin
          // inactive slot: skip without touching the output
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/mst_dp.sv -----
// Datapath: slot table, scan cursor and output register.
`timescale 1ns / 1ps
`include "multitouch_slot_tracker_assert.svh"
module mst_dp #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mst_pkg::mst_cmd_t        cmd,
  output mst_pkg::mst_sts_t        sts,
  input  logic              [15:0] ev_type,
  input  logic              [15:0] ev_code,
  input  logic signed       [31:0] ev_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     out_point_valid,
  output logic signed       [15:0] out_pos_x,
  output logic signed       [15:0] out_pos_y,
  output logic              [2:0]  out_finger_index,
  output logic                     out_last
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [MAX_SLOTS-1:0]    active_r, active_nxt;
  logic [15:0]             x_r [MAX_SLOTS];
  logic [15:0]             y_r [MAX_SLOTS];
  logic [SLOT_W-1:0]       cur_slot_r;
  logic [SLOT_W-1:0]       cursor_r;
  logic [mst_pkg::CNT_W-1:0] cnt_r;

  logic                    out_valid_r;
  logic                    out_point_valid_r;
  logic [15:0]             out_x_r;
  logic [15:0]             out_y_r;
  logic [2:0]              out_finger_r;
  logic                    out_last_r;

  logic                    is_abs;
  logic                    slot_ok;
  logic                    rest_active;
  logic                    load_out;

  assign is_abs  = (ev_type == mst_pkg::TYPE_ABS);
  assign slot_ok = !ev_value[31] && (ev_value[30:0] < 31'(MAX_SLOTS));

  // any active slot beyond the cursor
  always_comb begin
    rest_active = 1'b0;
    for (int j = 0; j < MAX_SLOTS; j++) begin
      if (active_r[j] && (SLOT_W'(j) > cursor_r)) begin
        rest_active = 1'b1;
      end
    end
  end

  always_comb begin
    active_nxt = active_r;
    if (cmd.apply_ev && is_abs && (ev_code == mst_pkg::CODE_TRACK)) begin
      active_nxt[cur_slot_r] = !ev_value[31];
    end
  end

  assign sts.any_active = |active_r;
  assign sts.cur_active = active_r[cursor_r];
  assign sts.cur_last   = !rest_active ||
                          (cnt_r == mst_pkg::CNT_W'(mst_pkg::RESULT_LIMIT - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign load_out = cmd.emit || cmd.emit_empty;

  // slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= '0;
      cur_slot_r <= '0;
      for (int k = 0; k < MAX_SLOTS; k++) begin
        x_r[k] <= '0;
        y_r[k] <= '0;
      end
    end else begin
      active_r <= active_nxt;
      if (cmd.apply_ev && is_abs) begin
        case (ev_code)
          mst_pkg::CODE_SLOT: begin
            if (slot_ok) begin
              cur_slot_r <= ev_value[SLOT_W-1:0];
            end
          end
          mst_pkg::CODE_X: x_r[cur_slot_r] <= ev_value[15:0];
          mst_pkg::CODE_Y: y_r[cur_slot_r] <= ev_value[15:0];
          default: ;
        endcase
      end
    end
  end

  // scan cursor and report count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      cnt_r    <= '0;
    end else if (cmd.start_scan) begin
      cursor_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cmd.advance) begin
        cursor_r <= cursor_r + SLOT_W'(1);
      end
      if (cmd.emit) begin
        cnt_r <= cnt_r + mst_pkg::CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_point_valid_r <= 1'b1;
      out_x_r           <= x_r[cursor_r];
      out_y_r           <= y_r[cursor_r];
      out_finger_r      <= 3'(cursor_r);
      out_last_r        <= sts.cur_last;
    end else if (cmd.emit_empty) begin
      out_point_valid_r <= 1'b0;
      out_x_r           <= '0;
      out_y_r           <= '0;
      out_finger_r      <= '0;
      out_last_r        <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_valid  = out_point_valid_r;
  assign out_pos_x        = out_x_r;
  assign out_pos_y        = out_y_r;
  assign out_finger_index = out_finger_r;
  assign out_last         = out_last_r;

  `MST_ASSERT_NOW(a_load_free, load_out, !out_valid_r || out_ready, "output overwritten")
  `MST_ASSERT_NOW(a_empty_only_idle, cmd.emit_empty, active_r == '0, "empty report with contacts")
  `MST_ASSERT_NEXT(a_empty_result, cmd.emit_empty,
                   out_valid_r && !out_point_valid_r && out_last_r, "bad empty result")
  `MST_ASSERT_NEXT(a_last_flag, cmd.emit && sts.cur_last, out_valid_r && out_last_r,
                   "final point not flagged")

endmodule

// ----- design/multitouch_slot_tracker.sv -----
// Top level: multitouch protocol B slot tracker with contact report on poll.
//
//  channel   | dir | handshake    | carries
//  in_ch     | in  | valid/ready  | req_type, ev_type, ev_code, ev_value
//  out_ch    | out | valid/ready  | point_valid, pos_x, pos_y, finger_index, last
//
// An event transaction updates the slot table in the cycle it is accepted.
// A poll walks the slot table one slot per cycle, stalling on an active slot
// while the output register is held by out_ch.ready low.
// Input is taken only between polls; one output register decouples out_ch.
// Synchronous active-low reset clears the slot table and current slot.
`timescale 1ns / 1ps
module multitouch_slot_tracker #(
  parameter int MAX_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  mst_in_if.sink    in_ch,
  mst_out_if.source out_ch
);

  mst_pkg::mst_cmd_t cmd;
  mst_pkg::mst_sts_t sts;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  mst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  mst_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .ev_type          (in_ch.ev_type),
    .ev_code          (in_ch.ev_code),
    .ev_value         (in_ch.ev_value),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_point_valid  (out_ch.point_valid),
    .out_pos_x        (out_ch.pos_x),
    .out_pos_y        (out_ch.pos_y),
    .out_finger_index (out_ch.finger_index),
    .out_last         (out_ch.last)
  );

endmodule
